@@ src/tdsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsc_pkg: shared definitions for the twist to drive/steer command block
// Item codes, register indexes, result layout and the CORDIC angle table.
// ----------------------------------------------------------------------------
package tdsc_pkg;

   // item kind on the request tuser bit
   localparam logic FUNC_CMD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // gear codes
   localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
   localparam logic [1:0] GEAR_REVERSE = 2'd1;
   localparam logic [1:0] GEAR_FORWARD = 2'd2;

   // steering rate codes
   localparam logic [8:0] RATE_STALE = 9'd120;
   localparam logic [8:0] RATE_FRESH = 9'd300;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_AXLE_SPAN  = 3'd0;
   localparam logic [2:0] REG_RPM_GAIN   = 3'd1;
   localparam logic [2:0] REG_MAX_RPM    = 3'd2;
   localparam logic [2:0] REG_MAX_STEER  = 3'd3;
   localparam logic [2:0] REG_STOP_MODE  = 3'd4;

   // register reset values
   localparam logic [14:0] AXLE_SPAN_RST  = 15'd4301;
   localparam logic [15:0] RPM_GAIN_RST   = 16'd4615;
   localparam logic [15:0] MAX_RPM_RST    = 16'd6000;
   localparam logic [12:0] MAX_STEER_RST  = 13'd3575;

   // result tdata layout, lowest bit first
   localparam int RSP_BRAKE_LSB = 0;
   localparam int RSP_GEAR_LSB  = 1;
   localparam int RSP_RPM_LSB   = 3;
   localparam int RSP_ANGLE_LSB = 19;
   localparam int RSP_RATE_LSB  = 33;
   localparam int RSP_CLEAN_LSB = 42;
   localparam int RSP_DATA_W    = 48;

   // angle accumulator width (Q20 radians, signed)
   localparam int ANGLE_ACC_W = 23;

   // atan(2^-i) in Q20, rounded
   function automatic logic [19:0] atan_q20(input logic [4:0] idx);
      logic [19:0] val;
      case (idx)
         5'd0:    val = 20'd823550;
         5'd1:    val = 20'd486170;
         5'd2:    val = 20'd256879;
         5'd3:    val = 20'd130396;
         5'd4:    val = 20'd65451;
         5'd5:    val = 20'd32757;
         5'd6:    val = 20'd16383;
         5'd7:    val = 20'd8192;
         5'd8:    val = 20'd4096;
         5'd9:    val = 20'd2048;
         5'd10:   val = 20'd1024;
         5'd11:   val = 20'd512;
         5'd12:   val = 20'd256;
         5'd13:   val = 20'd128;
         5'd14:   val = 20'd64;
         5'd15:   val = 20'd32;
         5'd16:   val = 20'd16;
         5'd17:   val = 20'd8;
         5'd18:   val = 20'd4;
         5'd19:   val = 20'd2;
         default: val = 20'd0;
      endcase
      return val;
   endfunction

endpackage

@@ src/twist_to_drive_steer_command.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twist_to_drive_steer_command: speed/turn-rate command to drive and steering
// Holds the last velocity command and, on each control tick, returns brake,
// gear, motor rpm, steering angle (bicycle model, CORDIC atan) and status.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------
//   req_     | in  | tvalid / tready    | tuser func, tdata speed, turn
//   rsp_     | out | tvalid / tready    | tdata brake .. cleaning_on
//   csr_     | in  | APB psel / penable | 5 registers at 4 * index
//
// A command item is taken while idle and gives no result. A stale tick
// goes straight to the result state. A fresh tick first runs the bit-serial
// multiply (the rpm and the steering numerator in parallel), loads the
// vector and runs CORDIC_STEPS micro-rotations of vectoring CORDIC, one per
// cycle. In the result state the result is formed and enters the output
// register once that register is free. The next item is taken from the
// cycle after the result is loaded.
// Reset is synchronous; registers return to their defaults, no command held.
// A stalled result waits in the output register; items are taken again
// once the block is back in idle, so a command may slip in while it waits.
// ----------------------------------------------------------------------------
module twist_to_drive_steer_command #(
   parameter int FRAC_BITS    = 12,
   parameter int CORDIC_STEPS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // [15:0] linear_speed, [31:16] turn_rate
   input  logic                        req_tuser,   // [0] func
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] brake, [2:1] gear, [18:3] motor_rpm, [32:19] steer_angle,
   // [41:33] steer_rate, [42] cleaning_on, [47:43] zero
   output logic [tdsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [4:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import tdsc_pkg::*;

   // thresholds in Q(FRAC_BITS)
   localparam int SPEED_MIN = ((1 << FRAC_BITS) + 50) / 100;
   localparam int TURN_RAW  = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam int TURN_MIN  = (TURN_RAW < 1) ? 1 : TURN_RAW;

   // CORDIC datapath width: covers max(|v| << FRAC_BITS, |w| * L) with gain
   localparam int XY_MAX = (FRAC_BITS + 15 > 30) ? FRAC_BITS + 15 : 30;
   localparam int CW     = XY_MAX + 3;
   localparam int IW     = $clog2(CORDIC_STEPS);
   localparam int ZW     = ANGLE_ACC_W;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ROT  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [14:0] axle_span_ff;
   logic [15:0] rpm_gain_ff;
   logic [15:0] max_rpm_ff;
   logic [12:0] max_steer_ff;
   logic        stop_mode_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         axle_span_ff  <= AXLE_SPAN_RST;
         rpm_gain_ff   <= RPM_GAIN_RST;
         max_rpm_ff    <= MAX_RPM_RST;
         max_steer_ff  <= MAX_STEER_RST;
         stop_mode_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_AXLE_SPAN:  axle_span_ff  <= csr_pwdata[14:0];
            REG_RPM_GAIN:   rpm_gain_ff   <= csr_pwdata[15:0];
            REG_MAX_RPM:    max_rpm_ff    <= csr_pwdata[15:0];
            REG_MAX_STEER:  max_steer_ff  <= csr_pwdata[12:0];
            REG_STOP_MODE:  stop_mode_ff  <= csr_pwdata[0];
            default: ;  // drop writes past the last register
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_AXLE_SPAN:  csr_prdata = {17'd0, axle_span_ff};
         REG_RPM_GAIN:   csr_prdata = {16'd0, rpm_gain_ff};
         REG_MAX_RPM:    csr_prdata = {16'd0, max_rpm_ff};
         REG_MAX_STEER:  csr_prdata = {19'd0, max_steer_ff};
         REG_STOP_MODE:  csr_prdata = {31'd0, stop_mode_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // held command and sequencer
   // ---------------------------------------------------------------------
   logic [1:0]           state_ff, state_in;
   logic signed [15:0]   held_speed_ff, held_turn_ff;
   logic                 fresh_ff;
   logic                 tick_fresh_ff;
   logic                 req_fire, tick_fire, cmd_fire, mul_start;
   logic [15:0]          abs_speed, abs_turn;
   logic                 rpm_busy, num_busy;
   logic [31:0]          rpm_prod;
   logic [30:0]          num_prod;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign cmd_fire   = req_fire & (req_tuser == FUNC_CMD);
   assign tick_fire  = req_fire & (req_tuser == FUNC_TICK);
   assign mul_start  = tick_fire & fresh_ff;

   // magnitudes; -(-32768) lands on 32768, which fits unsigned 16 bits
   assign abs_speed = held_speed_ff[15] ? 16'(-held_speed_ff) : 16'(held_speed_ff);
   assign abs_turn  = held_turn_ff[15]  ? 16'(-held_turn_ff)  : 16'(held_turn_ff);

   // |v| * rpm_gain and |w| * axle_span, one bit per cycle in parallel
   tdsc_sermul #(.AW(16), .BW(16)) u_rpm_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (abs_speed),
      .op_b  (rpm_gain_ff),
      .busy  (rpm_busy),
      .prod  (rpm_prod)
   );

   tdsc_sermul #(.AW(16), .BW(15)) u_num_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (abs_turn),
      .op_b  (axle_span_ff),
      .busy  (num_busy),
      .prod  (num_prod)
   );

   // ---------------------------------------------------------------------
   // CORDIC vectoring, one micro-rotation per cycle
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, x_sh, y_sh;
   logic signed [ZW-1:0] z_ff, z_in, step_ang;
   logic [IW-1:0]        it_ff, it_in;

   assign x_sh     = x_ff >>> it_ff;
   assign y_sh     = y_ff >>> it_ff;
   assign step_ang = signed'({{(ZW-20){1'b0}}, atan_q20(5'(it_ff))});

   // ---------------------------------------------------------------------
   // result forming
   // ---------------------------------------------------------------------
   logic                 moving, drive_on, steer_on, negate;
   logic [32:0]          rpm_round, rpm_scaled;
   logic [15:0]          rpm_val;
   logic [ZW-1:0]        z_pos, z_round;
   logic [ZW-9:0]        ang_full;
   logic [12:0]          ang_clamp;
   logic [13:0]          ang_val;
   logic [1:0]           gear_val;
   logic                 rsp_load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign moving   = (abs_speed >= 16'(SPEED_MIN));
   assign drive_on = tick_fresh_ff & moving & ~stop_mode_ff;
   assign steer_on = tick_fresh_ff & moving & (abs_turn >= 16'(TURN_MIN))
                   & (num_prod != '0);
   assign negate   = held_turn_ff[15] ^ held_speed_ff[15];

   // rpm: round half up out of Q(FRAC_BITS), clamp to max_rpm
   assign rpm_round  = {1'b0, rpm_prod} + (33'd1 << (FRAC_BITS - 1));
   assign rpm_scaled = rpm_round >> FRAC_BITS;
   assign rpm_val    = (rpm_scaled > {17'd0, max_rpm_ff}) ? max_rpm_ff : rpm_scaled[15:0];
   assign gear_val   = held_speed_ff[15] ? GEAR_REVERSE : GEAR_FORWARD;

   // angle: floor at zero, Q20 to Q12 half up, clamp to max_steer
   assign z_pos     = z_ff[ZW-1] ? '0 : z_ff;
   assign z_round   = z_pos + ZW'(128);
   assign ang_full  = z_round[ZW-1:8];
   assign ang_clamp = (ang_full > (ZW-8)'(max_steer_ff)) ? max_steer_ff : ang_full[12:0];
   assign ang_val   = negate ? -{1'b0, ang_clamp} : {1'b0, ang_clamp};

   assign rsp_load = (state_ff == S_DONE) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_BRAKE_LSB]                 = ~drive_on;
      rsp_data_in[RSP_GEAR_LSB +: 2]             = drive_on ? gear_val : GEAR_NEUTRAL;
      rsp_data_in[RSP_RPM_LSB +: 16]             = drive_on ? rpm_val : 16'd0;
      rsp_data_in[RSP_ANGLE_LSB +: 14]           = steer_on ? ang_val : 14'd0;
      rsp_data_in[RSP_RATE_LSB +: 9]             = tick_fresh_ff ? RATE_FRESH : RATE_STALE;
      rsp_data_in[RSP_CLEAN_LSB]                 = tick_fresh_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer next state and datapath updates
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      it_in    = it_ff;
      case (state_ff)
         S_IDLE: begin
            if (tick_fire) begin
               state_in = fresh_ff ? S_MUL : S_DONE;
            end
         end
         S_MUL: begin
            // load the vector once both products are in
            if (!rpm_busy && !num_busy) begin
               x_in     = CW'(abs_speed) <<< FRAC_BITS;
               y_in     = signed'(CW'(num_prod));
               z_in     = '0;
               it_in    = '0;
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            // rotate toward the x axis
            if (!y_ff[CW-1]) begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + step_ang;
            end else begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - step_ang;
            end
            it_in = it_ff + 1'b1;
            if (it_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      rsp_data_ff <= rsp_load ? rsp_data_in : rsp_data_ff;
      if (reset) begin
         state_ff      <= S_IDLE;
         it_ff         <= '0;
         fresh_ff      <= 1'b0;
         tick_fresh_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_speed_ff <= '0;
         held_turn_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         it_ff        <= it_in;
         rsp_valid_ff <= rsp_valid_in;
         // a command marks the held values fresh; a tick consumes the mark
         if (cmd_fire) begin
            held_speed_ff <= signed'(req_tdata[15:0]);
            held_turn_ff  <= signed'(req_tdata[31:16]);
            fresh_ff      <= 1'b1;
         end else if (tick_fire) begin
            fresh_ff      <= 1'b0;
            tick_fresh_ff <= fresh_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/tdsc_sermul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsc_sermul: bit-serial unsigned multiplier
// Takes one multiplier bit per cycle, LSB first; the product is ready
// once busy falls and holds until the next start.
// ----------------------------------------------------------------------------
module tdsc_sermul #(
   parameter int AW = 16,
   parameter int BW = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [AW-1:0]      op_a,
   input  logic [BW-1:0]      op_b,
   output logic               busy,
   output logic [AW+BW-1:0]   prod
);
   localparam int CNTW = $clog2(BW + 1);

   logic [AW+BW-1:0] prod_ff, prod_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [AW:0]      part_sum;

   // add the multiplicand into the upper half when the current bit is set
   assign part_sum = {1'b0, prod_ff[AW+BW-1:BW]} + (prod_ff[0] ? {1'b0, op_a} : '0);

   always_comb begin
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         prod_in = {{AW{1'b0}}, op_b};
         cnt_in  = CNTW'(BW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {part_sum, prod_ff[BW-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign prod = prod_ff;

endmodule

@@ src/tdsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsc_checker: port-level checks for twist_to_drive_steer_command
// Watches the result channel for consistent drive and steering fields.
// ----------------------------------------------------------------------------
module tdsc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tdsc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tdsc_pkg::*;

   logic        brake;
   logic [1:0]  gear;
   logic [15:0] rpm;
   logic [13:0] angle;
   logic [8:0]  rate;
   logic        clean;

   assign brake = rsp_tdata[RSP_BRAKE_LSB];
   assign gear  = rsp_tdata[RSP_GEAR_LSB +: 2];
   assign rpm   = rsp_tdata[RSP_RPM_LSB +: 16];
   assign angle = rsp_tdata[RSP_ANGLE_LSB +: 14];
   assign rate  = rsp_tdata[RSP_RATE_LSB +: 9];
   assign clean = rsp_tdata[RSP_CLEAN_LSB];

   // hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // braking means neutral and no rpm
   a_brake_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && brake |-> gear == GEAR_NEUTRAL && rpm == 16'd0)
      else $error("brake with gear or rpm set");

   // released brake means a drive gear
   a_drive_gear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !brake |-> gear == GEAR_FORWARD || gear == GEAR_REVERSE)
      else $error("brake released in neutral");

   // a stale item brakes and carries no steering and no cleaning
   a_stale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rate == RATE_STALE |-> brake && angle == 14'd0 && !clean)
      else $error("stale item with live command fields");

   // rate is one of the two codes and tracks the cleaning flag
   a_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rate == RATE_FRESH && clean) || (rate == RATE_STALE && !clean))
      else $error("steering rate code does not match cleaning flag");

endmodule

bind twist_to_drive_steer_command tdsc_checker u_tdsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
